// ===== src/mtbe_pkg.sv =====
package mtbe_pkg;

    localparam int TICKS_PER_QUARTER = 48;
    localparam int TICK_SCALE        = TICKS_PER_QUARTER / 48;
    localparam logic [15:0] TPQ_WORD = 16'(TICKS_PER_QUARTER);

    localparam int DELTA_W = 28;
    localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

    // tempo word = 60000000 / tempo_bpm, one quotient bit per cycle
    localparam int DIV_BITS  = 26;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);
    localparam logic [DIV_BITS-1:0] USEC_PER_MINUTE = DIV_BITS'(60000000);

    localparam int BPM_W    = 10;
    localparam int TRACKS_W = 16;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 4;

    localparam int IN_W  = 32;
    localparam int OUT_W = 40;

    localparam logic [7:0] BYTE_META     = 8'hFF;
    localparam logic [7:0] BYTE_TEMPO    = 8'h51;
    localparam logic [7:0] BYTE_EOT      = 8'h2F;
    localparam logic [7:0] BYTE_NOTE_ON  = 8'h90;
    localparam logic [7:0] BYTE_NOTE_OFF = 8'h80;
    localparam logic [7:0] BYTE_VELOCITY = 8'd64;
    localparam logic [7:0] BYTE_VLQ_MORE = 8'h80;

    localparam logic [IDX_W-1:0] LEN_HEADER = IDX_W'(14);
    localparam logic [IDX_W-1:0] LEN_TRACK  = IDX_W'(15);
    localparam logic [IDX_W-1:0] LEN_END    = IDX_W'(4);
    localparam logic [IDX_W-1:0] LEN_NOTE_FIXED = IDX_W'(6);

    typedef enum logic [2:0] {
        CMD_HEADER = 3'd0,
        CMD_TRACK  = 3'd1,
        CMD_REST   = 3'd2,
        CMD_NOTE   = 3'd3,
        CMD_END    = 3'd4
    } cmd_t;

    typedef enum logic {
        REG_TEMPO_BPM   = 1'b0,
        REG_TRACK_COUNT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t in_cmd;
        logic div_last;
        logic out_free;
        logic byte_last;
    } ctrl_stat_t;

    function automatic logic [2:0] vlq_groups(input logic [DELTA_W-1:0] v);
        logic [2:0] g;
        begin
            if (v[27:21] != 7'd0)
                g = 3'd4;
            else if (v[20:14] != 7'd0)
                g = 3'd3;
            else if (v[13:7] != 7'd0)
                g = 3'd2;
            else
                g = 3'd1;
            return g;
        end
    endfunction

    // byte j of a variable-length quantity of g groups, most significant first
    function automatic logic [7:0] vlq_byte(input logic [DELTA_W-1:0] v,
                                            input logic [2:0] g,
                                            input logic [2:0] j);
        logic [2:0] grp;
        logic [6:0] bits;
        begin
            grp = g - j - 3'd1;
            case (grp)
                3'd0: bits = v[6:0];
                3'd1: bits = v[13:7];
                3'd2: bits = v[20:14];
                3'd3: bits = v[27:21];
                default: bits = 7'd0;
            endcase
            return (grp != 3'd0) ? (BYTE_VLQ_MORE | {1'b0, bits}) : {1'b0, bits};
        end
    endfunction

endpackage

// ===== src/mtbe_ctrl.sv =====
module mtbe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output mtbe_pkg::ctrl_cmd_t   cmd,
    input  mtbe_pkg::ctrl_stat_t  stat
);
    import mtbe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.emit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    case (stat.in_cmd)
                        CMD_HEADER, CMD_NOTE, CMD_END: state_next = ST_EMIT;
                        CMD_TRACK:                     state_next = ST_DIV;
                        default:                       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.byte_last)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== src/mtbe_datapath.sv =====
module mtbe_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtbe_pkg::ctrl_cmd_t           cmd,
    output mtbe_pkg::ctrl_stat_t          stat,
    input  logic [mtbe_pkg::IN_W-1:0]     s_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [mtbe_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [mtbe_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tlast
);
    import mtbe_pkg::*;

    cmd_t                in_cmd;
    logic [15:0]         in_dur;
    logic [6:0]          in_note;
    logic [DELTA_W-1:0]  in_ticks;
    logic [2:0]          in_groups;
    logic [2:0]          rest_groups;
    logic [IDX_W-1:0]    note_len;
    logic [DELTA_W:0]    rest_sum;
    logic [32:0]         bytes_sum;

    logic [BPM_W-1:0]    tempo_bpm_reg;
    logic [TRACKS_W-1:0] track_count_reg;
    logic [DELTA_W-1:0]  rest_ticks_reg;
    logic [31:0]         track_bytes_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                out_valid_reg;

    cmd_t                cmd_reg;
    logic [6:0]          note_reg;
    logic [DELTA_W-1:0]  val1_reg;
    logic [DELTA_W-1:0]  val2_reg;
    logic [2:0]          g1_reg;
    logic [2:0]          g2_reg;
    logic [IDX_W-1:0]    n_reg;
    logic [BPM_W-1:0]    rem_reg;
    logic [DIV_BITS-1:0] quo_reg;
    logic [OUT_W-1:0]    out_data_reg;
    logic                out_last_reg;

    logic [BPM_W:0]      div_trial;
    logic                div_bit;
    logic [23:0]         tempo_word;
    logic [7:0]          cur_byte;
    logic [IDX_W-1:0]    p2;
    logic [IDX_W-1:0]    p3;
    logic [IDX_W-1:0]    p4;
    logic                byte_last;
    logic [31:0]         cur_length;

    assign in_cmd    = cmd_t'(s_tdata[2:0]);
    assign in_dur    = s_tdata[18:3];
    assign in_note   = s_tdata[25:19];
    assign in_ticks  = DELTA_W'(in_dur * TICK_SCALE);
    assign in_groups = vlq_groups(in_ticks);
    assign rest_groups = vlq_groups(rest_ticks_reg);
    assign note_len  = IDX_W'(in_groups) + IDX_W'(rest_groups) + LEN_NOTE_FIXED;
    assign rest_sum  = {1'b0, rest_ticks_reg} + {1'b0, in_ticks};

    always_comb
    begin
        case (in_cmd)
            CMD_NOTE: bytes_sum = {1'b0, track_bytes_reg} + 33'(note_len);
            default:  bytes_sum = {1'b0, track_bytes_reg} + 33'(LEN_END);
        endcase
    end

    // restoring divider step
    assign div_trial = {rem_reg, quo_reg[DIV_BITS-1]};
    assign div_bit   = (div_trial >= {1'b0, tempo_bpm_reg});
    assign tempo_word = (quo_reg[DIV_BITS-1:24] != '0) ? 24'hFFFFFF : quo_reg[23:0];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_bpm_reg   <= BPM_W'(120);
            track_count_reg <= TRACKS_W'(1);
            rest_ticks_reg  <= '0;
            track_bytes_reg <= '0;
            idx_reg         <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_TEMPO_BPM:   tempo_bpm_reg   <= cfg_data[BPM_W-1:0];
                    REG_TRACK_COUNT: track_count_reg <= cfg_data[TRACKS_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                idx_reg     <= '0;
                div_cnt_reg <= '0;
                case (in_cmd)
                    CMD_TRACK:
                    begin
                        rest_ticks_reg  <= '0;
                        track_bytes_reg <= 32'd7;
                    end
                    CMD_REST:
                        rest_ticks_reg <= rest_sum[DELTA_W] ? DELTA_MAX
                                                            : rest_sum[DELTA_W-1:0];
                    CMD_NOTE, CMD_END:
                    begin
                        rest_ticks_reg  <= '0;
                        track_bytes_reg <= bytes_sum[32] ? 32'hFFFFFFFF : bytes_sum[31:0];
                    end
                    default: ;
                endcase
            end
            if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            if (cmd.emit)
                idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg  <= in_cmd;
            note_reg <= in_note;
            val1_reg <= rest_ticks_reg;
            val2_reg <= in_ticks;
            g1_reg   <= rest_groups;
            g2_reg   <= in_groups;
            rem_reg  <= '0;
            quo_reg  <= USEC_PER_MINUTE;
            case (in_cmd)
                CMD_HEADER: n_reg <= LEN_HEADER;
                CMD_TRACK:  n_reg <= LEN_TRACK;
                CMD_NOTE:   n_reg <= note_len;
                default:    n_reg <= LEN_END;
            endcase
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_bit ? BPM_W'(div_trial - {1'b0, tempo_bpm_reg})
                               : div_trial[BPM_W-1:0];
            quo_reg <= {quo_reg[DIV_BITS-2:0], div_bit};
        end
        if (cmd.emit)
        begin
            out_data_reg <= {cur_length, cur_byte};
            out_last_reg <= byte_last;
        end
    end

    // byte at the current position of the running command
    always_comb
    begin
        cur_byte = 8'h00;
        p2 = idx_reg - IDX_W'(g1_reg);
        p3 = p2 - IDX_W'(3);
        p4 = p3 - IDX_W'(g2_reg);
        case (cmd_reg)
            CMD_HEADER:
            begin
                case (idx_reg)
                    4'd0:  cur_byte = "M";
                    4'd1:  cur_byte = "T";
                    4'd2:  cur_byte = "h";
                    4'd3:  cur_byte = "d";
                    4'd7:  cur_byte = 8'd6;
                    4'd9:  cur_byte = 8'd1;
                    4'd10: cur_byte = track_count_reg[15:8];
                    4'd11: cur_byte = track_count_reg[7:0];
                    4'd12: cur_byte = TPQ_WORD[15:8];
                    4'd13: cur_byte = TPQ_WORD[7:0];
                    default: cur_byte = 8'h00;
                endcase
            end
            CMD_TRACK:
            begin
                case (idx_reg)
                    4'd0:  cur_byte = "M";
                    4'd1:  cur_byte = "T";
                    4'd2:  cur_byte = "r";
                    4'd3:  cur_byte = "k";
                    4'd9:  cur_byte = BYTE_META;
                    4'd10: cur_byte = BYTE_TEMPO;
                    4'd11: cur_byte = 8'd3;
                    4'd12: cur_byte = tempo_word[23:16];
                    4'd13: cur_byte = tempo_word[15:8];
                    4'd14: cur_byte = tempo_word[7:0];
                    default: cur_byte = 8'h00;
                endcase
            end
            CMD_END:
            begin
                case (idx_reg)
                    4'd1:    cur_byte = BYTE_META;
                    4'd2:    cur_byte = BYTE_EOT;
                    default: cur_byte = 8'h00;
                endcase
            end
            CMD_NOTE:
            begin
                // delta, note on, duration delta, note off
                if (idx_reg < IDX_W'(g1_reg))
                    cur_byte = vlq_byte(val1_reg, g1_reg, idx_reg[2:0]);
                else if (p2 == IDX_W'(0))
                    cur_byte = BYTE_NOTE_ON;
                else if (p2 == IDX_W'(1))
                    cur_byte = {1'b0, note_reg};
                else if (p2 == IDX_W'(2))
                    cur_byte = BYTE_VELOCITY;
                else if (p3 < IDX_W'(g2_reg))
                    cur_byte = vlq_byte(val2_reg, g2_reg, p3[2:0]);
                else if (p4 == IDX_W'(0))
                    cur_byte = BYTE_NOTE_OFF;
                else if (p4 == IDX_W'(1))
                    cur_byte = {1'b0, note_reg};
                else
                    cur_byte = BYTE_VELOCITY;
            end
            default: cur_byte = 8'h00;
        endcase
    end

    assign byte_last  = (idx_reg == n_reg - IDX_W'(1));
    assign cur_length = (byte_last && cmd_reg == CMD_END) ? track_bytes_reg : 32'd0;

    assign stat.in_cmd    = in_cmd;
    assign stat.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_BITS - 1));
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.byte_last = byte_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/midi_track_byte_encoder.sv =====
// first byte: a taken command goes through the emit state and the output register,
// a track start through the 26-step tempo divider first; throughput: one byte per
// cycle while m_tready holds; header 14 bytes, note up to 13, track end 4, track start 15, rest none
// the result register lets the next command in while the last byte waits
// reset: asynchronous, active low; tempo 120 bpm, one track, pending delta and count zero
module midi_track_byte_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command[2:0], duration[18:3], note_number[25:19], zero fill
    input  logic [mtbe_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // data_byte[7:0], track_length[39:8]
    output logic [mtbe_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [mtbe_pkg::CFG_W-1:0]    cfg_data
);
    import mtbe_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    mtbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mtbe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== src/mtbe_checker.sv =====
module mtbe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mtbe_pkg::IN_W-1:0]     s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mtbe_pkg::OUT_W-1:0]    m_tdata,
    input logic                          m_tlast
);
    import mtbe_pkg::*;

    // a stalled transfer holds its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // track length only rides on the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[OUT_W-1:8] == 32'd0)
        else $error("track length on a non-final byte");

    // no new command while a command still has bytes to send
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken mid command");

    // a header command closes the input once it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[2:0] == CMD_HEADER |=> !s_tready)
        else $error("input open right after header");

endmodule

bind midi_track_byte_encoder mtbe_checker u_mtbe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
